// ===== rtl/crts_pkg.sv =====
// Shared types and constants for the column run threshold segmenter.
package crts_pkg;

    localparam int PIX_W    = 16;
    localparam int COORD_W  = 12;
    localparam int YEND_W   = 13;
    localparam int INDEX_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    // Output queue must hold the two results of one bin on top of what waits.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MODE       = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] threshold_high;
        logic [PIX_W-1:0] threshold_low;
        logic             led_mode;
    } cfg_t;

    typedef struct packed {
        logic             frame_first;
        logic             column_last;
        logic             column_first;
        logic [COORD_W-1:0] row_y;
        logic [COORD_W-1:0] column_x;
        logic [PIX_W-1:0] pixel_bottom_right;
        logic [PIX_W-1:0] pixel_bottom_left;
        logic [PIX_W-1:0] pixel_top_right;
        logic [PIX_W-1:0] pixel_top_left;
    } item_t;

    typedef struct packed {
        logic               last_of_run;
        logic [INDEX_W-1:0] seg_index;
        logic [YEND_W-1:0]  seg_y_end;
        logic [COORD_W-1:0] seg_y_start;
        logic [COORD_W-1:0] seg_x;
    } result_t;

    // Results of one bin, packed in order: slot 0 first.
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } push_t;

endpackage

// ===== rtl/crts_bin_judge.sv =====
// Marks a 2x2 bin against the intensity window (maximum or any-pixel rule).
module crts_bin_judge (
    input  crts_pkg::cfg_t  cfg,
    input  crts_pkg::item_t item,
    output logic            marked
);

    logic [crts_pkg::PIX_W-1:0] max_top;
    logic [crts_pkg::PIX_W-1:0] max_bottom;
    logic [crts_pkg::PIX_W-1:0] max_all;
    logic [3:0]                 pix_in;
    logic                       max_in;

    always_comb begin
        max_top    = (item.pixel_top_right > item.pixel_top_left) ?
                     item.pixel_top_right : item.pixel_top_left;
        max_bottom = (item.pixel_bottom_right > item.pixel_bottom_left) ?
                     item.pixel_bottom_right : item.pixel_bottom_left;
        max_all    = (max_bottom > max_top) ? max_bottom : max_top;

        pix_in[0] = (item.pixel_top_left >= cfg.threshold_low) &&
                    (item.pixel_top_left <= cfg.threshold_high);
        pix_in[1] = (item.pixel_top_right >= cfg.threshold_low) &&
                    (item.pixel_top_right <= cfg.threshold_high);
        pix_in[2] = (item.pixel_bottom_left >= cfg.threshold_low) &&
                    (item.pixel_bottom_left <= cfg.threshold_high);
        pix_in[3] = (item.pixel_bottom_right >= cfg.threshold_low) &&
                    (item.pixel_bottom_right <= cfg.threshold_high);
        max_in    = (max_all >= cfg.threshold_low) && (max_all <= cfg.threshold_high);

        marked = cfg.led_mode ? (|pix_in) : max_in;
    end

endmodule

// ===== rtl/crts_run_tracker.sv =====
// Run state per column and segment numbering; yields up to two segments per bin.
module crts_run_tracker #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  crts_pkg::item_t item,
    input  logic            marked,
    output crts_pkg::push_t push
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    logic                         prev_unmarked_reg, prev_unmarked_next;
    logic                         run_open_reg, run_open_next;
    logic [crts_pkg::COORD_W-1:0] run_start_reg, run_start_next;
    logic [crts_pkg::COORD_W-1:0] run_last_reg, run_last_next;
    logic [CNT_W-1:0]             seg_count_reg, seg_count_next;

    logic             pu, po, open1, start_run;
    logic [CNT_W-1:0] cnt0, cnt1;
    logic             emit_a, emit_b;
    crts_pkg::result_t res_a, res_b;

    always_comb begin
        cnt0 = item.frame_first ? '0 : seg_count_reg;
        pu   = item.column_first ? 1'b1 : prev_unmarked_reg;
        po   = item.column_first ? 1'b0 : run_open_reg;

        // A marked bin after an unmarked one closes the open run first.
        start_run = marked && pu;
        emit_a    = start_run && po && (cnt0 < MAX_CNT);
        cnt1      = cnt0 + CNT_W'(emit_a);

        run_start_next = start_run ? item.row_y : run_start_reg;
        run_last_next  = marked ? item.row_y : run_last_reg;
        open1          = marked | po;

        emit_b = item.column_last && open1 && (cnt1 < MAX_CNT);
        seg_count_next = cnt1 + CNT_W'(emit_b);

        run_open_next      = item.column_last ? 1'b0 : open1;
        prev_unmarked_next = item.column_last ? 1'b1 : !marked;

        res_a.seg_x       = item.column_x;
        res_a.seg_y_start = run_start_reg;
        res_a.seg_y_end   = {1'b0, run_last_reg} + 13'd1;
        res_a.seg_index   = crts_pkg::INDEX_W'(cnt0);
        res_a.last_of_run = !emit_b;

        res_b.seg_x       = item.column_x;
        res_b.seg_y_start = run_start_next;
        res_b.seg_y_end   = {1'b0, run_last_next} + 13'd1;
        res_b.seg_index   = crts_pkg::INDEX_W'(cnt1);
        res_b.last_of_run = 1'b1;

        // Compact: slot 0 holds the first segment that exists.
        push.res0  = emit_a ? res_a : res_b;
        push.res1  = res_b;
        push.count = step ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_unmarked_reg <= 1'b1;
            run_open_reg      <= 1'b0;
            run_start_reg     <= '0;
            run_last_reg      <= '0;
            seg_count_reg     <= '0;
        end else if (step) begin
            prev_unmarked_reg <= prev_unmarked_next;
            run_open_reg      <= run_open_next;
            run_start_reg     <= run_start_next;
            run_last_reg      <= run_last_next;
            seg_count_reg     <= seg_count_next;
        end
    end

endmodule

// ===== rtl/crts_out_queue.sv =====
// Small result queue: takes zero, one or two results per cycle, sends one when m_axis_tready allows.
module crts_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  crts_pkg::push_t   push,
    output logic              room_for_two,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output crts_pkg::result_t head
);

    crts_pkg::result_t            store_reg [crts_pkg::QUEUE_DEPTH];
    logic [crts_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [crts_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [crts_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [crts_pkg::QPTR_W-1:0]  wr_ptr_second;
    logic                         pop;

    always_comb begin
        m_axis_tvalid = (count_reg != '0);
        head          = store_reg[rd_ptr_reg];
        pop           = m_axis_tvalid && m_axis_tready;
        room_for_two  = (count_reg <= crts_pkg::QCNT_W'(crts_pkg::QUEUE_DEPTH - 2));
        wr_ptr_second = wr_ptr_reg + crts_pkg::QPTR_W'(1);
        wr_ptr_next   = wr_ptr_reg + crts_pkg::QPTR_W'(push.count);
        rd_ptr_next   = rd_ptr_reg + crts_pkg::QPTR_W'(pop);
        count_next    = count_reg + crts_pkg::QCNT_W'(push.count)
                        - crts_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            store_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            store_reg[wr_ptr_second] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/column_run_threshold_segmenter.sv =====
// Top level of the column run threshold segmenter.
//
// Bins (2x2 pixels) arrive on the s_axis channel, walking down each column:
// tlast marks the last bin of a column, tuser carries column_first and
// frame_first. Each bin is registered, judged against the intensity window
// and fed to the run tracker once the queue has room for two beats. A finished
// run leaves on the m_axis channel as one segment beat; a bin can yield zero,
// one or two beats, and m_axis_tlast marks the last beat caused by that bin.
// A bin waits in item_reg; its beats are then registered in the output queue.
// Throughput: one bin per cycle while results drain at one beat per cycle;
// a bin that closes two runs needs two output beats. The four-entry
// output queue decouples the sides, so bins keep flowing while a beat waits.
// Stall: when m_axis_tready stays low the queue fills and s_axis_tready drops
// until there is room for two more beats; nothing is lost or duplicated.
// Reset (aresetn low, synchronous): run state and segment count clear, the
// window opens to 0..65535 in maximum mode, both channels go empty. The window
// registers (cfg_wr_en/cfg_index/cfg_wr_data; index 0 low bound, 1 high bound,
// 2 LED mode): the user writes them only while idle, unenforced by the block.
module column_run_threshold_segmenter #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [crts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crts_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    // column_x, row_y
    input  logic [crts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // column_first, frame_first
    input  logic [crts_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                                s_axis_tlast,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // seg_x, seg_y_start, seg_y_end, seg_index, zero pad
    output logic [crts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    crts_pkg::cfg_t    cfg_reg;
    crts_pkg::item_t   item_reg, item_next;
    logic              item_valid_reg, item_valid_next;
    logic              marked;
    logic              room_for_two;
    logic              advance;
    logic              accept;
    crts_pkg::push_t   push;
    crts_pkg::result_t head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_low  <= '0;
            cfg_reg.threshold_high <= '1;
            cfg_reg.led_mode       <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                crts_pkg::CFG_THRESHOLD_LOW:  cfg_reg.threshold_low  <= cfg_wr_data;
                crts_pkg::CFG_THRESHOLD_HIGH: cfg_reg.threshold_high <= cfg_wr_data;
                crts_pkg::CFG_LED_MODE:       cfg_reg.led_mode       <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // Advance the held bin only when the queue can take both possible beats.
        advance       = item_valid_reg && room_for_two;
        s_axis_tready = !item_valid_reg || advance;
        accept        = s_axis_tvalid && s_axis_tready;

        item_next.pixel_top_left     = s_axis_tdata[15:0];
        item_next.pixel_top_right    = s_axis_tdata[31:16];
        item_next.pixel_bottom_left  = s_axis_tdata[47:32];
        item_next.pixel_bottom_right = s_axis_tdata[63:48];
        item_next.column_x           = s_axis_tdata[75:64];
        item_next.row_y              = s_axis_tdata[87:76];
        item_next.column_first       = s_axis_tuser[0];
        item_next.frame_first        = s_axis_tuser[1];
        item_next.column_last        = s_axis_tlast;

        item_valid_next = accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    crts_bin_judge u_judge (
        .cfg    (cfg_reg),
        .item   (item_reg),
        .marked (marked)
    );

    crts_run_tracker #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .marked  (marked),
        .push    (push)
    );

    crts_out_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .room_for_two  (room_for_two),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head          (head)
    );

    assign m_axis_tdata = {1'b0, head.seg_index, head.seg_y_end,
                           head.seg_y_start, head.seg_x};
    assign m_axis_tlast = head.last_of_run;

endmodule

// ===== bench/tb_column_run_threshold_segmenter.sv =====
// Self-checking bench for the column run threshold segmenter: random columns, stalls, windows.
module tb_column_run_threshold_segmenter;

    localparam int SEG_CAP      = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [crts_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [crts_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    // column_x, row_y
    logic [crts_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // column_first, frame_first
    logic [crts_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // seg_x, seg_y_start, seg_y_end, seg_index, zero pad
    logic [crts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    column_run_threshold_segmenter #(.MAX_SEGMENTS(SEG_CAP)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Window copy and run tracker of the predictor
    logic [15:0] win_low = 16'd0;
    logic [15:0] win_high = 16'hFFFF;
    logic        led_any = 1'b0;
    logic        gap_before = 1'b1;
    logic        run_active = 1'b0;
    logic [11:0] run_top = '0;
    logic [11:0] run_bottom = '0;
    int          seg_count = 0;

    crts_pkg::item_t   bins_pending[$];
    crts_pkg::result_t segments_due[$];
    crts_pkg::result_t bin_segs[$];
    int      errors = 0;
    int      cycles = 0;

    int tx_mode = 0;
    int rx_mode = 0;
    int holdoff_asked = 0;
    int holdoff_taken = 0;
    int holdoff_left = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_tick = 0;
    crts_pkg::item_t next_bin;

    function automatic crts_pkg::item_t make_bin(input logic [15:0] p0, p1, p2, p3,
                                                 input logic [11:0] x, y,
                                                 input logic cf, cl, ff);
        crts_pkg::item_t b;
        b.pixel_top_left     = p0;
        b.pixel_top_right    = p1;
        b.pixel_bottom_left  = p2;
        b.pixel_bottom_right = p3;
        b.column_x           = x;
        b.row_y              = y;
        b.column_first       = cf;
        b.column_last        = cl;
        b.frame_first        = ff;
        return b;
    endfunction

    function automatic logic in_win(input logic [15:0] p);
        return p >= win_low && p <= win_high;
    endfunction

    task automatic add_segment(input logic [11:0] x);
        crts_pkg::result_t r;
        if (seg_count < SEG_CAP) begin
            r.seg_x       = x;
            r.seg_y_start = run_top;
            r.seg_y_end   = {1'b0, run_bottom} + 13'd1;
            r.seg_index   = seg_count[crts_pkg::INDEX_W-1:0];
            r.last_of_run = 1'b0;
            bin_segs.push_back(r);
            seg_count++;
        end
    endtask

    task automatic predict_segments(input crts_pkg::item_t b);
        logic        hit;
        logic [15:0] peak;
        bin_segs.delete();
        if (b.frame_first)
            seg_count = 0;
        if (b.column_first) begin
            gap_before = 1'b1;
            run_active = 1'b0;
        end
        peak = b.pixel_top_left;
        if (b.pixel_top_right > peak) peak = b.pixel_top_right;
        if (b.pixel_bottom_left > peak) peak = b.pixel_bottom_left;
        if (b.pixel_bottom_right > peak) peak = b.pixel_bottom_right;
        if (led_any)
            hit = in_win(b.pixel_top_left) || in_win(b.pixel_top_right) ||
                  in_win(b.pixel_bottom_left) || in_win(b.pixel_bottom_right);
        else
            hit = in_win(peak);
        if (hit) begin
            // a new run closes the one still open in this column
            if (gap_before) begin
                if (run_active)
                    add_segment(b.column_x);
                run_top = b.row_y;
            end
            run_bottom = b.row_y;
            run_active = 1'b1;
            gap_before = 1'b0;
        end else begin
            gap_before = 1'b1;
        end
        if (b.column_last) begin
            if (run_active)
                add_segment(b.column_x);
            run_active = 1'b0;
            gap_before = 1'b1;
        end
        if (bin_segs.size() > 0)
            bin_segs[bin_segs.size()-1].last_of_run = 1'b1;
        foreach (bin_segs[i])
            segments_due.push_back(bin_segs[i]);
    endtask

    task automatic same_field(input string name, input logic [12:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_segment();
        crts_pkg::result_t got;
        crts_pkg::result_t want;
        got = {m_axis_tlast, m_axis_tdata[crts_pkg::OUT_TDATA_W-2:0]};
        if (segments_due.size() == 0) begin
            $display("%0t: segment beat with none expected, got %h", $time, got);
            errors++;
        end else begin
            want = segments_due.pop_front();
            same_field("seg_x", want.seg_x, got.seg_x);
            same_field("seg_y_start", want.seg_y_start, got.seg_y_start);
            same_field("seg_y_end", want.seg_y_end, got.seg_y_end);
            same_field("seg_index", want.seg_index, got.seg_index);
            same_field("last_of_run", want.last_of_run, got.last_of_run);
        end
    endtask

    // Check outgoing beats before predicting, so a fresh bin never masks a stray beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                check_segment();
            if (s_axis_tvalid && s_axis_tready)
                predict_segments({s_axis_tuser[1], s_axis_tlast, s_axis_tuser[0], s_axis_tdata});
        end
    end

    // Bin driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0 || bins_pending.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                next_bin = bins_pending.pop_front();
                s_axis_tdata  <= next_bin[crts_pkg::IN_TDATA_W-1:0];
                s_axis_tuser  <= {next_bin.frame_first, next_bin.column_first};
                s_axis_tlast  <= next_bin.column_last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(16, 1);
                    case (tx_mode)
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(3, 0);
                        default: gap_left = $urandom_range(12, 0);
                    endcase
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Segment receiver: stall pattern per mode, plus long hold-offs on request
    always @(posedge aclk) begin
        rx_tick++;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else if (holdoff_taken < holdoff_asked) begin
            holdoff_taken++;
            holdoff_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(3, 0) != 0);
                2: m_axis_tready <= ($urandom_range(2, 0) == 0);
                default: m_axis_tready <= (rx_tick[3:2] != 2'b11);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[column_run_threshold_segmenter] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [crts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            crts_pkg::CFG_THRESHOLD_LOW:  win_low = val;
            crts_pkg::CFG_THRESHOLD_HIGH: win_high = val;
            crts_pkg::CFG_LED_MODE:       led_any = val[0];
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [15:0] lo, hi, input logic led);
        write_reg(crts_pkg::CFG_THRESHOLD_LOW, lo);
        write_reg(crts_pkg::CFG_THRESHOLD_HIGH, hi);
        write_reg(crts_pkg::CFG_LED_MODE, {15'd0, led});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every bin is taken and every segment is back, then let the pipe drain
    task automatic wait_idle();
        @(negedge aclk);
        while (bins_pending.size() != 0 || s_axis_tvalid || segments_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // kind: 0 inside window, 1 below, 2 above, 3 near a bound or rail, else anything
    function automatic logic [15:0] pick_pixel(input int kind);
        int lo;
        int hi;
        lo = win_low;
        hi = win_high;
        case (kind)
            0: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
            1: return (lo > 0) ? $urandom_range(lo - 1, 0) : 16'd0;
            2: return (hi < 65535) ? $urandom_range(65535, hi + 1) : 16'hFFFF;
            3: begin
                case ($urandom_range(5, 0))
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return lo;
                    3: return hi;
                    4: return lo - 1;
                    default: return hi + 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic crts_pkg::item_t random_bin(input logic [11:0] x, y,
                                                   input logic cf, cl, ff);
        logic [15:0] p[4];
        int profile;
        int hot;
        profile = $urandom_range(9, 0);
        hot = $urandom_range(3, 0);
        foreach (p[i]) begin
            case (profile)
                0, 1, 2, 3: p[i] = pick_pixel($urandom_range(1, 0));
                4, 5:       p[i] = (i == hot) ? pick_pixel(2) : pick_pixel($urandom_range(4, 0));
                6, 7:       p[i] = pick_pixel($urandom_range(2, 1));
                8:          p[i] = pick_pixel(3);
                default:    p[i] = $urandom;
            endcase
        end
        return make_bin(p[0], p[1], p[2], p[3], x, y, cf, cl, ff);
    endfunction

    // Columns walking down the image, with some broken ones mixed in
    task automatic push_random(input int n_bins);
        int          pushed;
        int          rows;
        int          step;
        int          shape;
        logic [11:0] x;
        logic [11:0] y;
        logic        ff;
        pushed = 0;
        while (pushed < n_bins) begin
            shape = $urandom_range(19, 0);
            rows = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 1);
            step = $urandom_range(2, 1);
            case ($urandom_range(9, 0))
                0: x = 12'd0;
                1: x = 12'hFFF;
                default: x = $urandom;
            endcase
            case ($urandom_range(9, 0))
                0, 1: y = 12'd0;
                2: y = 12'hFFF - rows * step + step;
                default: y = $urandom;
            endcase
            ff = ($urandom_range(3, 0) == 0);
            for (int i = 0; i < rows; i++) begin
                if (shape == 0)
                    bins_pending.push_back(random_bin($urandom, $urandom, $urandom, $urandom,
                                                      $urandom_range(7, 0) == 0));
                else
                    bins_pending.push_back(random_bin(x, y,
                                                      i == 0 && shape != 1 && shape != 2,
                                                      i == rows - 1 && shape != 3 && shape != 4,
                                                      i == 0 && ff));
                y = y + step;
            end
            pushed += rows;
        end
    endtask

    initial begin
        logic [15:0] lo;
        logic [15:0] hi;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: maximum mode, window 100..60000
        set_window(16'd100, 16'd60000, 1'b0);
        bins_pending.push_back(make_bin(0, 0, 0, 0, 0, 0, 1, 0, 1));
        bins_pending.push_back(make_bin(0, 0, 0, 60000, 0, 2, 0, 0, 0));
        bins_pending.push_back(make_bin(100, 99, 0, 50, 0, 4, 0, 0, 0));
        bins_pending.push_back(make_bin(60001, 0, 0, 0, 0, 6, 0, 0, 0));
        bins_pending.push_back(make_bin(1000, 1000, 1000, 1000, 0, 8, 0, 0, 0));
        bins_pending.push_back(make_bin(5, 0, 60000, 7, 12'hFFF, 10, 0, 1, 0));
        // column from row zero, then two runs closed by one bin
        bins_pending.push_back(make_bin(200, 0, 0, 0, 10, 0, 1, 0, 0));
        bins_pending.push_back(make_bin(0, 0, 0, 0, 10, 2, 0, 0, 0));
        bins_pending.push_back(make_bin(300, 300, 300, 300, 10, 4, 0, 1, 0));
        // next column without column_first after a closed column
        bins_pending.push_back(make_bin(500, 0, 0, 0, 11, 0, 0, 0, 0));
        bins_pending.push_back(make_bin(0, 0, 0, 16'hFFFF, 11, 4094, 0, 0, 0));
        bins_pending.push_back(make_bin(60000, 60000, 60000, 60000, 11, 12'hFFF, 0, 0, 0));
        // run carried into a column that lacks column_first
        bins_pending.push_back(make_bin(100, 0, 0, 0, 2048, 0, 0, 0, 0));
        bins_pending.push_back(make_bin(0, 0, 0, 0, 2048, 2, 0, 1, 0));
        bins_pending.push_back(make_bin(100, 0, 0, 0, 2049, 12'hFFF, 1, 1, 0));
        wait_idle();

        set_window(16'd100, 16'd60000, 1'b1);
        bins_pending.push_back(make_bin(0, 500, 16'hFFFF, 16'hFFFF, 7, 0, 1, 0, 1));
        bins_pending.push_back(make_bin(0, 99, 60001, 16'hFFFF, 7, 2, 0, 1, 0));
        bins_pending.push_back(make_bin(16'hFFFF, 16'hFFFF, 16'hFFFF, 60000, 8, 0, 1, 1, 0));
        wait_idle();

        // inverted window marks nothing in either mode
        set_window(16'd5000, 16'd4000, 1'b1);
        bins_pending.push_back(make_bin(4000, 5000, 4500, 0, 9, 0, 1, 0, 0));
        bins_pending.push_back(make_bin(4500, 4500, 4500, 4500, 9, 2, 0, 1, 0));
        wait_idle();
        set_window(16'd5000, 16'd4000, 1'b0);
        bins_pending.push_back(make_bin(5000, 4000, 4500, 4999, 9, 0, 1, 1, 1));
        wait_idle();

        // Random phases over several windows
        for (int ph = 0; ph < 7; ph++) begin
            lo = $urandom_range(40000, 0);
            hi = $urandom_range(65535, lo);
            case (ph)
                0: set_window(16'd0, 16'hFFFF, 1'b0);
                1: set_window(16'd0, 16'hFFFF, 1'b1);
                2: set_window(lo, hi, 1'b0);
                3: set_window(lo, hi, 1'b1);
                4: set_window(16'hFFFF, 16'hFFFF, 1'b0);
                5: set_window(16'd0, 16'd0, 1'b1);
                default: set_window($urandom, $urandom, $urandom_range(1, 0));
            endcase
            tx_mode = ph % 3;
            rx_mode = ph % 4;
            push_random(50);
            if (ph == 2 || ph == 5)
                holdoff_asked++;
            wait_idle();
        end

        // Fill the segment list of one frame past its capacity
        set_window(16'd1, 16'hFFFF, 1'b0);
        tx_mode = 1;
        rx_mode = 1;
        bins_pending.push_back(make_bin($urandom_range(65535, 1), $urandom, $urandom, $urandom,
                                        $urandom, $urandom, 1, 1, 1));
        for (int i = 1; i < SEG_CAP - 3; i++)
            bins_pending.push_back(make_bin($urandom_range(65535, 1), $urandom, $urandom,
                                            $urandom, $urandom, $urandom,
                                            $urandom_range(1, 0), 1, 0));
        for (int k = 0; k < 2; k++) begin
            bins_pending.push_back(make_bin(7, 0, 0, 0, $urandom, 100, 0, 0, 0));
            bins_pending.push_back(make_bin(0, 0, 0, 0, $urandom, 102, 0, 0, 0));
            bins_pending.push_back(make_bin(9, 0, 0, 0, $urandom, 104, 0, 1, 0));
        end
        bins_pending.push_back(make_bin(11, 0, 0, 0, 12'hFFF, 200, 1, 1, 0));
        bins_pending.push_back(make_bin(13, 0, 0, 0, 12'd3, 300, 1, 1, 1));
        wait_idle();

        if (errors == 0)
            $display("[column_run_threshold_segmenter] OK");
        else
            $display("[column_run_threshold_segmenter] ERROR");
        $finish;
    end

endmodule

// ===== column_run_threshold_segmenter.f =====
rtl/crts_pkg.sv
rtl/crts_bin_judge.sv
rtl/crts_run_tracker.sv
rtl/crts_out_queue.sv
rtl/column_run_threshold_segmenter.sv
bench/tb_column_run_threshold_segmenter.sv
